[design/qmn_pkg.sv]
// Shared constants for the normalized quaternion product pipeline.
package qmn_pkg;

  localparam int unsigned CW_DEFAULT = 16;
  localparam int unsigned FB_DEFAULT = 14;
  localparam int unsigned NORM_MSB   = 29;
  localparam int unsigned NORM_WIDTH = NORM_MSB + 1;
  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned RAD_WIDTH  = 2 * SQRT_STEPS;
  localparam int unsigned NUM_TERMS  = 16;

  // Hamilton product terms: component index 0..3 = x, y, z, w
  localparam int unsigned TERM_A [NUM_TERMS] = '{3, 0, 1, 2,  3, 1, 2, 0,
                                                 3, 2, 0, 1,  3, 0, 1, 2};
  localparam int unsigned TERM_B [NUM_TERMS] = '{0, 3, 2, 1,  1, 3, 0, 2,
                                                 2, 3, 1, 0,  3, 0, 1, 2};
  localparam logic [NUM_TERMS-1:0] TERM_SUB = 16'b1110_1000_1000_1000;

endpackage

[design/qmn_isqrt.sv]
// Pipelined bitwise integer square root, one result bit per stage.
module qmn_isqrt #(
  parameter int unsigned SIDE_WIDTH = 1
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  input  logic [qmn_pkg::RAD_WIDTH-1:0]      radicand_i,
  input  logic [SIDE_WIDTH-1:0]              side_i,
  output logic                               valid_o,
  output logic [qmn_pkg::SQRT_STEPS-1:0]     root_o,
  output logic [SIDE_WIDTH-1:0]              side_o
);
  import qmn_pkg::*;

  logic [RAD_WIDTH-1:0]  x_q    [SQRT_STEPS+1];
  logic [RAD_WIDTH-1:0]  res_q  [SQRT_STEPS+1];
  logic [SIDE_WIDTH-1:0] side_q [SQRT_STEPS+1];
  logic [SQRT_STEPS:0]   valid_q;

  always_comb begin
    x_q[0]     = radicand_i;
    res_q[0]   = '0;
    side_q[0]  = side_i;
    valid_q[0] = valid_i;
  end

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
    localparam logic [RAD_WIDTH-1:0] Bit = RAD_WIDTH'(1) << (RAD_WIDTH - 2 - 2 * i);
    logic [RAD_WIDTH-1:0] trial;
    logic [RAD_WIDTH-1:0] x_d, res_d;

    always_comb begin
      trial = res_q[i] + Bit;
      if (x_q[i] >= trial) begin
        x_d   = x_q[i] - trial;
        res_d = (res_q[i] >> 1) + Bit;
      end else begin
        x_d   = x_q[i];
        res_d = res_q[i] >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      x_q[i+1]    <= x_d;
      res_q[i+1]  <= res_d;
      side_q[i+1] <= side_q[i];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i+1] <= 1'b0;
      end else begin
        valid_q[i+1] <= valid_q[i];
      end
    end
  end

  assign valid_o = valid_q[SQRT_STEPS];
  assign root_o  = res_q[SQRT_STEPS][SQRT_STEPS-1:0];
  assign side_o  = side_q[SQRT_STEPS];

endmodule

[design/qmn_div.sv]
// Pipelined restoring division of four magnitudes by the length, rounded.
module qmn_div #(
  parameter int unsigned FRACTION_BITS = qmn_pkg::FB_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  logic                                zero_i,
  input  logic [qmn_pkg::NORM_WIDTH-1:0]      mag_i [4],
  input  logic [3:0]                          neg_i,
  input  logic [qmn_pkg::SQRT_STEPS-1:0]      len_i,
  output logic                                valid_o,
  output logic                                zero_o,
  output logic [FRACTION_BITS+1:0]            quot_o [4],
  output logic [3:0]                          neg_o
);
  import qmn_pkg::*;

  localparam int unsigned QW = FRACTION_BITS + 2;
  localparam int unsigned NW = NORM_WIDTH + FRACTION_BITS + 1;
  localparam int unsigned RW = SQRT_STEPS;

  logic [RW-1:0] rem_q  [QW+1][4];
  logic [QW-1:0] low_q  [QW+1][4];
  logic [QW-1:0] quo_q  [QW+1][4];
  logic [RW-1:0] len_q  [QW+1];
  logic [3:0]    neg_q  [QW+1];
  logic          zero_q [QW+1];
  logic [QW:0]   valid_q;

  for (genvar c = 0; c < 4; c++) begin : g_num
    logic [NW-1:0] num;
    assign num = (NW'(mag_i[c]) << FRACTION_BITS) + NW'(len_i >> 1);
    always_ff @(posedge clk_i) begin
      rem_q[0][c] <= RW'(num >> QW);
      low_q[0][c] <= num[QW-1:0];
      quo_q[0][c] <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q[0]  <= len_i;
    neg_q[0]  <= neg_i;
    zero_q[0] <= zero_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else begin
      valid_q[0] <= valid_i;
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_stage
    for (genvar c = 0; c < 4; c++) begin : g_comp
      logic [RW-1:0] trial;
      assign trial = {rem_q[j][c][RW-2:0], low_q[j][c][QW-1]};
      always_ff @(posedge clk_i) begin
        if (trial >= len_q[j]) begin
          rem_q[j+1][c] <= trial - len_q[j];
          quo_q[j+1][c] <= {quo_q[j][c][QW-2:0], 1'b1};
        end else begin
          rem_q[j+1][c] <= trial;
          quo_q[j+1][c] <= {quo_q[j][c][QW-2:0], 1'b0};
        end
        low_q[j+1][c] <= low_q[j][c] << 1;
      end
    end

    always_ff @(posedge clk_i) begin
      len_q[j+1]  <= len_q[j];
      neg_q[j+1]  <= neg_q[j];
      zero_q[j+1] <= zero_q[j];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[j+1] <= 1'b0;
      end else begin
        valid_q[j+1] <= valid_q[j];
      end
    end
  end

  assign valid_o = valid_q[QW];
  assign zero_o  = zero_q[QW];
  assign neg_o   = neg_q[QW];
  assign quot_o  = quo_q[QW];

endmodule

[design/quaternion_multiply_normalize_core.sv]
// Top level of the normalized quaternion product pipeline.
// Takes one quaternion pair per cycle; busy is never raised. Each word
// appears on the result ports for one cycle with done_o. The pipeline
// runs through the 32-stage square root and the one-bit-per-stage
// divider. Results cannot be held off, so take them as they come.
module quaternion_multiply_normalize_core #(
  parameter int unsigned COMPONENT_WIDTH = qmn_pkg::CW_DEFAULT,
  parameter int unsigned FRACTION_BITS   = qmn_pkg::FB_DEFAULT
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [COMPONENT_WIDTH-1:0]  a_x_i,
  input  logic signed [COMPONENT_WIDTH-1:0]  a_y_i,
  input  logic signed [COMPONENT_WIDTH-1:0]  a_z_i,
  input  logic signed [COMPONENT_WIDTH-1:0]  a_w_i,
  input  logic signed [COMPONENT_WIDTH-1:0]  b_x_i,
  input  logic signed [COMPONENT_WIDTH-1:0]  b_y_i,
  input  logic signed [COMPONENT_WIDTH-1:0]  b_z_i,
  input  logic signed [COMPONENT_WIDTH-1:0]  b_w_i,
  output logic                               done_o,
  output logic signed [COMPONENT_WIDTH-1:0]  r_x_o,
  output logic signed [COMPONENT_WIDTH-1:0]  r_y_o,
  output logic signed [COMPONENT_WIDTH-1:0]  r_z_o,
  output logic signed [COMPONENT_WIDTH-1:0]  r_w_o,
  output logic                               zero_length_o
);
  import qmn_pkg::*;

  localparam int unsigned CW   = COMPONENT_WIDTH;
  localparam int unsigned PW   = 2 * CW;
  localparam int unsigned TW   = (CW > 31) ? PW - 2 : PW;
  localparam int unsigned SW   = TW + 2;
  localparam int unsigned PosW = $clog2(SW);
  localparam int unsigned QW   = FRACTION_BITS + 2;
  localparam int unsigned SQW  = 2 * NORM_WIDTH;
  localparam int unsigned SBW  = 4 * NORM_WIDTH + 5;
  localparam int unsigned Latency = 9 + SQRT_STEPS + QW;
  localparam logic [63:0] PosMax = (64'(1) << (CW - 1)) - 64'(1);
  localparam logic [63:0] NegMax = 64'(1) << (CW - 1);

  logic signed [PW-1:0] ae [4];
  logic signed [PW-1:0] be [4];
  logic [7:1]           v_q;

  assign busy = 1'b0;

  always_comb begin
    ae[0] = PW'(a_x_i); ae[1] = PW'(a_y_i); ae[2] = PW'(a_z_i); ae[3] = PW'(a_w_i);
    be[0] = PW'(b_x_i); be[1] = PW'(b_y_i); be[2] = PW'(b_z_i); be[3] = PW'(b_w_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[6:1], start & ~busy};
    end
  end

  // products
  logic signed [TW-1:0] term_q [NUM_TERMS];
  for (genvar t = 0; t < NUM_TERMS; t++) begin : g_term
    logic signed [PW-1:0] prod;
    assign prod = ae[TERM_A[t]] * be[TERM_B[t]];
    always_ff @(posedge clk_i) begin
      term_q[t] <= TW'(prod >>> (PW - TW));
    end
  end

  // component sums
  logic signed [SW-1:0] p_q [4];
  for (genvar k = 0; k < 4; k++) begin : g_sum
    logic signed [SW-1:0] acc;
    always_comb begin
      acc = '0;
      for (int j = 0; j < 4; j++) begin
        if (TERM_SUB[4*k+j]) begin
          acc = acc - SW'(term_q[4*k+j]);
        end else begin
          acc = acc + SW'(term_q[4*k+j]);
        end
      end
    end
    always_ff @(posedge clk_i) begin
      p_q[k] <= acc;
    end
  end

  // magnitudes
  logic [SW-1:0] mag_q [4];
  logic [3:0]    neg_q;
  logic [SW-1:0] any_q;
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 4; k++) begin
      neg_q[k] <= p_q[k][SW-1];
      mag_q[k] <= p_q[k][SW-1] ? SW'(-p_q[k]) : SW'(p_q[k]);
    end
    any_q <= (p_q[0][SW-1] ? SW'(-p_q[0]) : SW'(p_q[0]))
           | (p_q[1][SW-1] ? SW'(-p_q[1]) : SW'(p_q[1]))
           | (p_q[2][SW-1] ? SW'(-p_q[2]) : SW'(p_q[2]))
           | (p_q[3][SW-1] ? SW'(-p_q[3]) : SW'(p_q[3]));
  end

  // leading one
  logic [PosW-1:0] pos_d, pos_q;
  logic [SW-1:0]   mag4_q [4];
  logic [3:0]      neg4_q;
  logic            zero4_q;
  always_comb begin
    pos_d = '0;
    for (int i = 0; i < SW; i++) begin
      if (any_q[i]) begin
        pos_d = PosW'(i);
      end
    end
  end
  always_ff @(posedge clk_i) begin
    pos_q   <= pos_d;
    mag4_q  <= mag_q;
    neg4_q  <= neg_q;
    zero4_q <= (any_q == '0);
  end

  // block scaling
  logic [NORM_WIDTH-1:0] norm_q [4];
  logic [3:0]            neg5_q;
  logic                  zero5_q;
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 4; k++) begin
      if (pos_q > PosW'(NORM_MSB)) begin
        norm_q[k] <= NORM_WIDTH'(mag4_q[k] >> (pos_q - PosW'(NORM_MSB)));
      end else begin
        norm_q[k] <= NORM_WIDTH'(mag4_q[k]) << (PosW'(NORM_MSB) - pos_q);
      end
    end
    neg5_q  <= neg4_q;
    zero5_q <= zero4_q;
  end

  // squares
  logic [SQW-1:0]        sq_q   [4];
  logic [NORM_WIDTH-1:0] norm6_q [4];
  logic [3:0]            neg6_q;
  logic                  zero6_q;
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 4; k++) begin
      sq_q[k] <= SQW'(norm_q[k]) * SQW'(norm_q[k]);
    end
    norm6_q <= norm_q;
    neg6_q  <= neg5_q;
    zero6_q <= zero5_q;
  end

  // sum of squares
  logic [RAD_WIDTH-1:0]  rad_q;
  logic [NORM_WIDTH-1:0] norm7_q [4];
  logic [3:0]            neg7_q;
  logic                  zero7_q;
  always_ff @(posedge clk_i) begin
    rad_q   <= RAD_WIDTH'(sq_q[0]) + RAD_WIDTH'(sq_q[1])
             + RAD_WIDTH'(sq_q[2]) + RAD_WIDTH'(sq_q[3]);
    norm7_q <= norm6_q;
    neg7_q  <= neg6_q;
    zero7_q <= zero6_q;
  end

  logic [SBW-1:0]         side_in, side_out;
  logic                   sq_valid;
  logic [SQRT_STEPS-1:0]  len;
  logic [NORM_WIDTH-1:0]  dmag [4];

  assign side_in = {zero7_q, neg7_q, norm7_q[3], norm7_q[2], norm7_q[1], norm7_q[0]};

  qmn_isqrt #(
    .SIDE_WIDTH(SBW)
  ) u_isqrt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (v_q[7]),
    .radicand_i(rad_q),
    .side_i    (side_in),
    .valid_o   (sq_valid),
    .root_o    (len),
    .side_o    (side_out)
  );

  for (genvar k = 0; k < 4; k++) begin : g_unpack
    assign dmag[k] = side_out[k*NORM_WIDTH +: NORM_WIDTH];
  end

  logic          dv_valid, dv_zero;
  logic [QW-1:0] quot [4];
  logic [3:0]    dv_neg;

  qmn_div #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(sq_valid),
    .zero_i (side_out[SBW-1]),
    .mag_i  (dmag),
    .neg_i  (side_out[SBW-2 -: 4]),
    .len_i  (len),
    .valid_o(dv_valid),
    .zero_o (dv_zero),
    .quot_o (quot),
    .neg_o  (dv_neg)
  );

  // saturate and sign
  logic [CW-1:0] res_d [4];
  for (genvar k = 0; k < 4; k++) begin : g_sat
    logic [63:0] q64, qs;
    always_comb begin
      q64 = 64'(quot[k]);
      if (dv_neg[k]) begin
        qs       = (q64 > NegMax) ? NegMax : q64;
        res_d[k] = CW'(64'(0) - qs);
      end else begin
        qs       = (q64 > PosMax) ? PosMax : q64;
        res_d[k] = CW'(qs);
      end
      if (dv_zero) begin
        res_d[k] = '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    r_x_o         <= res_d[0];
    r_y_o         <= res_d[1];
    r_z_o         <= res_d[2];
    r_w_o         <= res_d[3];
    zero_length_o <= dv_zero;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= dv_valid;
    end
  end

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##(Latency) done_o)
    else $error("result word missing at fixed latency");

  a_zero_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && zero_length_o) |->
      (r_x_o == '0 && r_y_o == '0 && r_z_o == '0 && r_w_o == '0))
    else $error("zero length word carries nonzero components");

  a_unit_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !zero_length_o) |->
      (r_x_o != '0 || r_y_o != '0 || r_z_o != '0 || r_w_o != '0))
    else $error("normalized word is all zero");

endmodule

[tb/sv/quaternion_multiply_normalize_core_tb.sv]
// Self-checking testbench for the normalized quaternion product core.
`timescale 1ns / 100ps

module quaternion_multiply_normalize_core_tb;

  localparam int unsigned CW = qmn_pkg::CW_DEFAULT;
  localparam int unsigned FB = qmn_pkg::FB_DEFAULT;
  localparam int unsigned LATENCY = 41 + FB + 2;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned N_RANDOM = 1080;

  typedef logic signed [CW-1:0] comp_t;

  typedef struct packed {
    comp_t ax, ay, az, aw, bx, by, bz, bw;
  } qpair_t;

  typedef struct packed {
    comp_t x, y, z, w;
    logic  zl;
  } unit_quat_t;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  start = 1'b0;
  logic  busy;
  comp_t a_x_i = '0, a_y_i = '0, a_z_i = '0, a_w_i = '0;
  comp_t b_x_i = '0, b_y_i = '0, b_z_i = '0, b_w_i = '0;
  logic  done_o;
  comp_t r_x_o, r_y_o, r_z_o, r_w_o;
  logic  zero_length_o;

  qpair_t     pending_q[$];
  unit_quat_t expected_q[$];
  int         idle_pct = 0;
  int         errors = 0;
  int         accepted = 0;
  int         checked = 0;
  int         zero_seen = 0;
  int         quiet_cycles = 0;
  bit         drain_hold = 1'b0;

  quaternion_multiply_normalize_core u_dut (
    .clk_i, .rst_ni, .start, .busy,
    .a_x_i, .a_y_i, .a_z_i, .a_w_i, .b_x_i, .b_y_i, .b_z_i, .b_w_i,
    .done_o, .r_x_o, .r_y_o, .r_z_o, .r_w_o, .zero_length_o
  );

  always #4 clk_i = ~clk_i;

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic unit_quat_t normalized_product(qpair_t q);
    longint          p[4];
    longint unsigned mag[4];
    bit              neg[4];
    longint unsigned top, sum, len, qv, pmax, nmax;
    int              msb;
    unit_quat_t      r;
    p[0] = q.aw * q.bx + q.ax * q.bw + q.ay * q.bz - q.az * q.by;
    p[1] = q.aw * q.by + q.ay * q.bw + q.az * q.bx - q.ax * q.bz;
    p[2] = q.aw * q.bz + q.az * q.bw + q.ax * q.by - q.ay * q.bx;
    p[3] = q.aw * q.bw - q.ax * q.bx - q.ay * q.by - q.az * q.bz;
    top = 0;
    sum = 0;
    for (int i = 0; i < 4; i++) begin
      neg[i] = p[i] < 0;
      mag[i] = neg[i] ? -p[i] : p[i];
      if (mag[i] > top) top = mag[i];
    end
    r = '0;
    if (top == 0) begin
      r.zl = 1'b1;
      return r;
    end
    msb = 0;
    while (msb < 63 && (top >> (msb + 1)) != 0) msb++;
    for (int i = 0; i < 4; i++) begin
      if (msb > 29) mag[i] = mag[i] >> (msb - 29);
      else mag[i] = mag[i] << (29 - msb);
      sum += mag[i] * mag[i];
    end
    len = root64(sum);
    pmax = (64'd1 << (CW - 1)) - 1;
    nmax = 64'd1 << (CW - 1);
    for (int i = 0; i < 4; i++) begin
      qv = ((mag[i] << FB) + len / 2) / len;
      if (neg[i]) begin
        if (qv > nmax) qv = nmax;
        qv = -qv;
      end else if (qv > pmax) begin
        qv = pmax;
      end
      case (i)
        0: r.x = qv[CW-1:0];
        1: r.y = qv[CW-1:0];
        2: r.z = qv[CW-1:0];
        default: r.w = qv[CW-1:0];
      endcase
    end
    return r;
  endfunction

  function automatic comp_t pick_comp();
    case ($urandom_range(0, 9))
      0: return comp_t'(16'sh8000);
      1: return comp_t'(16'sh7fff);
      2: return '0;
      3: return comp_t'($urandom_range(0, 8) - 4);
      4: return comp_t'(16'sh4000);
      default: return comp_t'($urandom);
    endcase
  endfunction

  // driver
  always @(posedge clk_i) begin
    qpair_t q;
    if (rst_ni) begin
      if (start && !busy) begin
        accepted <= accepted + 1;
        expected_q.push_back(normalized_product({a_x_i, a_y_i, a_z_i, a_w_i,
                                                 b_x_i, b_y_i, b_z_i, b_w_i}));
      end
      if ((!start || !busy) && pending_q.size() > 0 && !drain_hold &&
          $urandom_range(0, 99) >= idle_pct) begin
        q = pending_q.pop_front();
        start <= 1'b1;
        {a_x_i, a_y_i, a_z_i, a_w_i, b_x_i, b_y_i, b_z_i, b_w_i} <= q;
      end else if (!start || !busy) begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    unit_quat_t e;
    int         bad;
    bad = 0;
    if (rst_ni && done_o) begin
      checked <= checked + 1;
      if (zero_length_o) zero_seen <= zero_seen + 1;
      if (expected_q.size() == 0) begin
        $error("unexpected word: r_x=%0d r_y=%0d r_z=%0d r_w=%0d zero_length=%0b",
               r_x_o, r_y_o, r_z_o, r_w_o, zero_length_o);
        bad++;
      end else begin
        e = expected_q.pop_front();
        if (r_x_o !== e.x) begin
          $error("r_x: expected %0d, got %0d", e.x, r_x_o); bad++;
        end
        if (r_y_o !== e.y) begin
          $error("r_y: expected %0d, got %0d", e.y, r_y_o); bad++;
        end
        if (r_z_o !== e.z) begin
          $error("r_z: expected %0d, got %0d", e.z, r_z_o); bad++;
        end
        if (r_w_o !== e.w) begin
          $error("r_w: expected %0d, got %0d", e.w, r_w_o); bad++;
        end
        if (zero_length_o !== e.zl) begin
          $error("zero_length: expected %0b, got %0b", e.zl, zero_length_o);
          bad++;
        end
      end
      errors <= errors + bad;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic add_pair(comp_t ax, ay, az, aw, bx, by, bz, bw);
    pending_q.push_back({ax, ay, az, aw, bx, by, bz, bw});
  endtask

  task automatic wait_drained();
    while (pending_q.size() > 0 || start || expected_q.size() > 0) @(posedge clk_i);
  endtask

  initial begin
    comp_t mn, mx, one;
    int    phase_pct[4];
    mn = comp_t'(16'sh8000);
    mx = comp_t'(16'sh7fff);
    one = comp_t'(16'sh4000);
    phase_pct = '{0, 48, 0, 31};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    add_pair(0, 0, 0, one, 0, 0, 0, one);
    add_pair(0, 0, 0, 0, 0, 0, 0, 0);
    add_pair(one, 0, 0, 0, 0, 0, 0, 0);
    add_pair(mx, mx, mx, mx, mx, mx, mx, mx);
    add_pair(mn, mn, mn, mn, mn, mn, mn, mn);
    add_pair(mn, mx, mn, mx, mx, mn, mx, mn);
    add_pair(mn, 0, 0, 0, mn, 0, 0, 0);
    add_pair(0, 0, 0, 1, 0, 0, 0, 1);
    add_pair(0, 0, 0, -1, 0, 0, 0, 1);
    add_pair(1, 0, 0, 0, 0, 1, 0, 0);
    add_pair(0, 0, 0, mn, 0, 0, 0, mn);
    add_pair(0, 0, 0, mn, 0, 0, 0, mx);
    add_pair(one, one, one, one, one, -one, one, -one);
    add_pair(1, 1, 1, 1, -1, -1, -1, 1);
    add_pair(mx, 0, 0, 0, 0, 0, mx, 0);
    add_pair(0, 1, 0, 0, 0, 0, 0, mn);
    add_pair(-1, -1, -1, -1, 0, 0, 0, -1);
    add_pair(comp_t'(16'h5555), comp_t'(16'haaaa), comp_t'(16'h5555), comp_t'(16'haaaa),
             comp_t'(16'haaaa), comp_t'(16'h5555), comp_t'(16'haaaa), comp_t'(16'h5555));
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = phase_pct[ph];
      for (int n = 0; n < N_RANDOM / 4; n++) begin
        if ($urandom_range(0, 19) == 0)
          add_pair(0, 0, 0, 0, pick_comp(), pick_comp(), pick_comp(), pick_comp());
        else
          add_pair(pick_comp(), pick_comp(), pick_comp(), pick_comp(),
                   pick_comp(), pick_comp(), pick_comp(), pick_comp());
      end
      // pause the sender mid-stream until all words are back
      while (pending_q.size() > N_RANDOM / 8) @(posedge clk_i);
      drain_hold = 1'b1;
      while (start || expected_q.size() > 0) @(posedge clk_i);
      drain_hold = 1'b0;
      wait_drained();
    end

    repeat (LATENCY + 10) @(posedge clk_i);
    $display("covered %0d pairs, %0d words checked, %0d zero-length words",
             accepted, checked, zero_seen);
    $display("idle phases 0/48/0/31 percent with one full drain per phase");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
